// ===== design/servo_status_reply_parser_top_defines.svh =====
// assertion macros for the servo status reply parser
// used by srp_ctrl, no other dependencies
`ifndef SERVO_STATUS_REPLY_PARSER_TOP_DEFINES_SVH
`define SERVO_STATUS_REPLY_PARSER_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define SRP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/srp_pkg.sv =====
// shared types and constants of the servo status reply parser
// no dependencies
`timescale 1ns / 1ps

package srp_pkg;

    localparam int CNT_W          = 8;
    localparam int MAX_MOTORS_DEF = 16;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [15:0] SPEED_MASK = 16'h03FF;
    localparam logic [3:0] RECORD_LEN  = 4'd9;

    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_REG  = 2'd1;
    localparam logic [1:0] ACT_NEW  = 2'd2;

    localparam logic [2:0] ST_RECORD = 3'd0;
    localparam logic [2:0] ST_BAD    = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_ADDED  = 3'd3;
    localparam logic [2:0] ST_DUP    = 3'd4;
    localparam logic [2:0] ST_FULL   = 3'd5;

    // lookup token passed along the id cells
    typedef struct packed {
        logic             valid;
        logic [7:0]       key;
        logic             hit;
        logic [CNT_W-1:0] slot;
    } t_query;

    // table write
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] idx;
        logic [7:0]       id;
    } t_wr;

    typedef struct packed {
        logic [2:0]  status;
        logic        matched;
        logic [3:0]  slot;
        logic [7:0]  record_id;
        logic [15:0] position;
        logic [9:0]  speed;
        logic [15:0] load;
        logic [7:0]  voltage;
        logic [7:0]  temperature;
        logic        last_record;
    } t_rsp;

endpackage

// ===== design/srp_req_if.sv =====
// input channel of the servo status reply parser
// no dependencies
`timescale 1ns / 1ps

interface srp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [7:0] new_motor_id;

    modport source (output valid, action, rx_byte, new_motor_id, input ready);
    modport sink (input valid, action, rx_byte, new_motor_id, output ready);
endinterface

// ===== design/srp_rsp_if.sv =====
// result channel of the servo status reply parser
// no dependencies
`timescale 1ns / 1ps

interface srp_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        matched;
    logic [3:0]  slot;
    logic [7:0]  record_id;
    logic [15:0] position;
    logic [9:0]  speed;
    logic [15:0] load;
    logic [7:0]  voltage;
    logic [7:0]  temperature;
    logic        last_record;

    modport source (output valid, status, matched, slot, record_id, position, speed, load,
                    voltage, temperature, last_record, input ready);
    modport sink (input valid, status, matched, slot, record_id, position, speed, load,
                  voltage, temperature, last_record, output ready);
endinterface

// ===== design/servo_status_reply_parser_top.sv =====
// Servo status reply parser, top level.
// Input words on i_req: action 0 feeds one received byte, 1 registers a motor id,
// 2 restarts the frame parser (table kept). Result words leave on o_rsp.
// Frame: 0xFF, reply opcode (i_cfg_we / i_cfg_wdata), count, then 9-byte records.
// A byte that completes no record and raises no error gives no word.
// A completed record or a registration walks the id through a row of MAX_MOTORS
// cells, one cell per cycle; its word then goes to the pending register and, once
// the output register is free, into it, and only then is the next item taken.
// Bad header and empty frame words skip the cells, going to the pending register.
// i_req.ready is high whenever no item is in work, also while a result word waits.
// If the receiver stalls, a finished word waits in the pending register until the
// output register frees; no input is taken meanwhile.
// Reset clears the parser, the motor count and the opcode register; table ids
// read as unknown until registered and are only compared below the count.
// depends on srp_pkg, srp_req_if, srp_rsp_if, srp_cell, srp_ctrl
`timescale 1ns / 1ps

module servo_status_reply_parser_top #(
    parameter int MAX_MOTORS = srp_pkg::MAX_MOTORS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srp_req_if.sink    i_req,
    srp_rsp_if.source  o_rsp,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    srp_pkg::t_query           w_q [MAX_MOTORS+1];
    srp_pkg::t_wr              w_wr;
    logic [srp_pkg::CNT_W-1:0] w_count;

    srp_ctrl #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_query     (w_q[0]),
        .i_hit       (w_q[MAX_MOTORS]),
        .o_wr        (w_wr),
        .o_count     (w_count)
    );

    for (genvar g = 0; g < MAX_MOTORS; g++) begin : g_cell
        srp_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_q     (w_q[g]),
            .i_wr    (w_wr),
            .i_count (w_count),
            .o_q     (w_q[g+1])
        );
    end

endmodule

// ===== design/srp_cell.sv =====
// one motor id cell of the lookup chain
// depends on srp_pkg
`timescale 1ns / 1ps

module srp_cell #(
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  srp_pkg::t_query           i_q,
    input  srp_pkg::t_wr              i_wr,
    input  logic [srp_pkg::CNT_W-1:0] i_count,
    output srp_pkg::t_query           o_q
);

    localparam logic [srp_pkg::CNT_W-1:0] L_IDX = srp_pkg::CNT_W'(IDX);

    logic [7:0]      r_id;
    srp_pkg::t_query r_q;
    srp_pkg::t_query n_q;
    logic            w_active;

    assign w_active = (L_IDX < i_count);

    always_comb begin
        n_q = i_q;
        if (!i_q.hit && w_active && (r_id == i_q.key)) begin
            n_q.hit  = 1'b1;
            n_q.slot = L_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == L_IDX)) begin
            r_id <= i_wr.id;
        end
        r_q.key  <= n_q.key;
        r_q.hit  <= n_q.hit;
        r_q.slot <= n_q.slot;
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q.valid <= n_q.valid;
        end
    end

    assign o_q = r_q;

endmodule

// ===== design/srp_ctrl.sv =====
// frame parser, table bookkeeping and result register
// depends on srp_pkg, srp_req_if, srp_rsp_if and the defines header
`timescale 1ns / 1ps
`include "servo_status_reply_parser_top_defines.svh"

module srp_ctrl #(
    parameter int MAX_MOTORS = srp_pkg::MAX_MOTORS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    srp_req_if.sink                   i_req,
    srp_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [7:0]                i_cfg_wdata,
    output srp_pkg::t_query           o_query,
    input  srp_pkg::t_query           i_hit,
    output srp_pkg::t_wr              o_wr,
    output logic [srp_pkg::CNT_W-1:0] o_count
);

    localparam logic [srp_pkg::CNT_W-1:0] L_MAX = srp_pkg::CNT_W'(MAX_MOTORS);

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EMIT} t_state;
    typedef enum logic [2:0] {
        PH_HEADER, PH_OPCODE, PH_COUNT, PH_RECORD, PH_DISCARD, PH_DONE
    } t_phase;

    t_state                    r_state, n_state;
    t_phase                    r_phase, n_phase;
    logic [3:0]                r_byte_idx, n_byte_idx;
    logic [7:0]                r_left, n_left;
    logic [63:0]               r_rec, n_rec;
    logic [7:0]                r_cur_id, n_cur_id;
    logic [7:0]                r_key, n_key;
    logic                      r_is_reg, n_is_reg;
    logic                      r_last, n_last;
    logic [srp_pkg::CNT_W-1:0] r_count, n_count;
    logic [7:0]                r_opcode, n_opcode;
    srp_pkg::t_rsp             r_pend, n_pend;
    srp_pkg::t_rsp             r_out, n_out;
    logic                      r_out_valid, n_out_valid;
    srp_pkg::t_query           w_query;
    srp_pkg::t_wr              w_wr;
    logic                      w_accept;
    logic [2:0]                w_sel;
    logic [7:0]                w_left_dec;
    logic [15:0]               w_speed;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_sel       = 3'(r_byte_idx - 4'd1);
    assign w_left_dec  = r_left - 8'd1;
    assign w_speed     = r_rec[31:16] & srp_pkg::SPEED_MASK;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_byte_idx  = r_byte_idx;
        n_left      = r_left;
        n_rec       = r_rec;
        n_cur_id    = r_cur_id;
        n_key       = r_key;
        n_is_reg    = r_is_reg;
        n_last      = r_last;
        n_count     = r_count;
        n_opcode    = i_cfg_we ? i_cfg_wdata : r_opcode;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        w_query     = '0;
        w_wr        = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.action)
                        srp_pkg::ACT_BYTE: begin
                            case (r_phase)
                                PH_HEADER: begin
                                    if (i_req.rx_byte == srp_pkg::HEADER_BYTE) begin
                                        n_phase = PH_OPCODE;
                                    end else begin
                                        n_phase        = PH_DISCARD;
                                        n_pend         = '0;
                                        n_pend.status  = srp_pkg::ST_BAD;
                                        n_state        = S_EMIT;
                                    end
                                end
                                PH_OPCODE: begin
                                    if (i_req.rx_byte == r_opcode) begin
                                        n_phase = PH_COUNT;
                                    end else begin
                                        n_phase        = PH_DISCARD;
                                        n_pend         = '0;
                                        n_pend.status  = srp_pkg::ST_BAD;
                                        n_state        = S_EMIT;
                                    end
                                end
                                PH_COUNT: begin
                                    if (i_req.rx_byte == 8'd0) begin
                                        n_phase        = PH_DONE;
                                        n_pend         = '0;
                                        n_pend.status  = srp_pkg::ST_EMPTY;
                                        n_state        = S_EMIT;
                                    end else begin
                                        n_left     = i_req.rx_byte;
                                        n_byte_idx = 4'd0;
                                        n_phase    = PH_RECORD;
                                    end
                                end
                                PH_RECORD: begin
                                    if (r_byte_idx == 4'd0) begin
                                        n_cur_id = i_req.rx_byte;
                                    end else begin
                                        n_rec[8*w_sel +: 8] = i_req.rx_byte;
                                    end
                                    if (r_byte_idx == srp_pkg::RECORD_LEN - 4'd1) begin
                                        n_byte_idx    = 4'd0;
                                        n_last        = (r_left == 8'd1);
                                        n_left        = w_left_dec;
                                        if (w_left_dec == 8'd0) begin
                                            n_phase = PH_DONE;
                                        end
                                        n_is_reg      = 1'b0;
                                        n_key         = r_cur_id;
                                        w_query.valid = 1'b1;
                                        w_query.key   = r_cur_id;
                                        n_state       = S_LOOK;
                                    end else begin
                                        n_byte_idx = r_byte_idx + 4'd1;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        srp_pkg::ACT_REG: begin
                            n_is_reg      = 1'b1;
                            n_key         = i_req.new_motor_id;
                            w_query.valid = 1'b1;
                            w_query.key   = i_req.new_motor_id;
                            n_state       = S_LOOK;
                        end
                        srp_pkg::ACT_NEW: begin
                            n_phase    = PH_HEADER;
                            n_byte_idx = 4'd0;
                            n_left     = 8'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOOK: begin
                if (i_hit.valid) begin
                    n_pend  = '0;
                    n_state = S_EMIT;
                    if (r_is_reg) begin
                        if (i_hit.hit) begin
                            n_pend.status  = srp_pkg::ST_DUP;
                            n_pend.matched = 1'b1;
                            n_pend.slot    = i_hit.slot[3:0];
                        end else if (r_count >= L_MAX) begin
                            n_pend.status = srp_pkg::ST_FULL;
                        end else begin
                            w_wr.en       = 1'b1;
                            w_wr.idx      = r_count;
                            w_wr.id       = r_key;
                            n_pend.status = srp_pkg::ST_ADDED;
                            n_pend.slot   = r_count[3:0];
                            n_count       = r_count + 1'b1;
                        end
                    end else begin
                        n_pend.status      = srp_pkg::ST_RECORD;
                        n_pend.matched     = i_hit.hit;
                        n_pend.slot        = i_hit.hit ? i_hit.slot[3:0] : 4'd0;
                        n_pend.record_id   = r_key;
                        n_pend.position    = r_rec[15:0];
                        n_pend.speed       = w_speed[9:0];
                        n_pend.load        = r_rec[47:32];
                        n_pend.voltage     = r_rec[55:48];
                        n_pend.temperature = r_rec[63:56];
                        n_pend.last_record = r_last;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec    <= n_rec;
        r_cur_id <= n_cur_id;
        r_key    <= n_key;
        r_is_reg <= n_is_reg;
        r_last   <= n_last;
        r_pend   <= n_pend;
        r_out    <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_HEADER;
            r_byte_idx  <= 4'd0;
            r_left      <= 8'd0;
            r_count     <= '0;
            r_opcode    <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_byte_idx  <= n_byte_idx;
            r_left      <= n_left;
            r_count     <= n_count;
            r_opcode    <= n_opcode;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_query = w_query;
    assign o_wr    = w_wr;
    assign o_count = r_count;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.matched     = r_out.matched;
    assign o_rsp.slot        = r_out.slot;
    assign o_rsp.record_id   = r_out.record_id;
    assign o_rsp.position    = r_out.position;
    assign o_rsp.speed       = r_out.speed;
    assign o_rsp.load        = r_out.load;
    assign o_rsp.voltage     = r_out.voltage;
    assign o_rsp.temperature = r_out.temperature;
    assign o_rsp.last_record = r_out.last_record;

    `SRP_ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, r_count <= L_MAX,
        "motor count above table size")
    `SRP_ASSERT_IMPL(a_hit_in_look, i_clk, i_rst_n, i_hit.valid, r_state == S_LOOK,
        "lookup result outside lookup state")
    `SRP_ASSERT_NEXT(a_look_to_emit, i_clk, i_rst_n, (r_state == S_LOOK) && i_hit.valid,
        r_state == S_EMIT, "lookup result not followed by emit")
    `SRP_ASSERT_IMPL(a_wr_room, i_clk, i_rst_n, o_wr.en, (r_count < L_MAX) && !i_hit.hit,
        "table write without room or on a known id")

endmodule

// ===== tb/sv/tb_servo_status_reply_parser_top.sv =====
// testbench for servo_status_reply_parser_top: drives input words through random framed
// replies, registrations and noise, predicts result words and checks them field by field
// depends on srp_pkg, srp_req_if, srp_rsp_if and the parser rtl
`timescale 1ns / 1ps

module tb_servo_status_reply_parser_top;

    localparam int MOTOR_SLOTS  = srp_pkg::MAX_MOTORS_DEF;
    localparam int DRAIN_CYCLES = MOTOR_SLOTS + 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 310;
    localparam int NUM_PHASES   = 5;

    localparam logic [1:0] ACT_IGNORED = 2'd3;

    typedef enum logic [2:0] {
        WAIT_HDR,
        WAIT_OPC,
        WAIT_CNT,
        IN_RECORD,
        DISCARD,
        FRAME_DONE
    } t_parse_state;

    class reply_scoreboard;
        logic [7:0]     opcode_reg;
        t_parse_state   state;
        logic [3:0]     byte_idx;
        logic [7:0]     records_left;
        logic [63:0]    rec_bytes;
        logic [7:0]     rec_id;
        logic [7:0]     motor_ids [MOTOR_SLOTS];
        int             motor_total;
        srp_pkg::t_rsp  expected_words [$];
        int             errors;
        int             words_checked;
        int             record_words;
        int             frame_errors;
        int             reg_words;

        function new();
            opcode_reg    = 8'h00;
            state         = WAIT_HDR;
            byte_idx      = 4'd0;
            records_left  = 8'd0;
            rec_bytes     = 64'd0;
            rec_id        = 8'd0;
            motor_total   = 0;
            errors        = 0;
            words_checked = 0;
            record_words  = 0;
            frame_errors  = 0;
            reg_words     = 0;
        endfunction

        function void set_opcode(logic [7:0] value);
            opcode_reg = value;
        endfunction

        function void queue_word(srp_pkg::t_rsp w);
            expected_words.insert(expected_words.size(), w);
        endfunction

        function bit lookup(input logic [7:0] id, output int slot);
            slot = 0;
            for (int i = 0; i < motor_total && i < MOTOR_SLOTS; i++) begin
                if (motor_ids[i] == id) begin
                    slot = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // returns 0 when the word is ignored by the parser
        function bit note_item(logic [1:0] act, logic [7:0] rx, logic [7:0] new_id);
            srp_pkg::t_rsp w;
            bit   busy;
            bit   hit;
            int   slot;
            int   k;
            w    = '0;
            busy = 1'b1;
            case (act)
                srp_pkg::ACT_BYTE: begin
                    case (state)
                        WAIT_HDR: begin
                            if (rx == srp_pkg::HEADER_BYTE) begin
                                state = WAIT_OPC;
                            end else begin
                                state    = DISCARD;
                                w.status = srp_pkg::ST_BAD;
                                queue_word(w);
                                frame_errors++;
                            end
                        end
                        WAIT_OPC: begin
                            if (rx == opcode_reg) begin
                                state = WAIT_CNT;
                            end else begin
                                state    = DISCARD;
                                w.status = srp_pkg::ST_BAD;
                                queue_word(w);
                                frame_errors++;
                            end
                        end
                        WAIT_CNT: begin
                            if (rx == 8'd0) begin
                                state    = FRAME_DONE;
                                w.status = srp_pkg::ST_EMPTY;
                                queue_word(w);
                                frame_errors++;
                            end else begin
                                records_left = rx;
                                byte_idx     = 4'd0;
                                rec_bytes    = 64'd0;
                                state        = IN_RECORD;
                            end
                        end
                        IN_RECORD: begin
                            if (byte_idx == 4'd0) begin
                                rec_id = rx;
                            end else begin
                                k = int'(byte_idx) - 1;
                                rec_bytes[8*k +: 8] = rx;
                            end
                            byte_idx = byte_idx + 4'd1;
                            if (byte_idx == srp_pkg::RECORD_LEN) begin
                                byte_idx      = 4'd0;
                                hit           = lookup(rec_id, slot);
                                w.status      = srp_pkg::ST_RECORD;
                                w.matched     = hit;
                                w.slot        = hit ? slot[3:0] : 4'd0;
                                w.record_id   = rec_id;
                                w.position    = rec_bytes[15:0];
                                w.speed       = rec_bytes[25:16];
                                w.load        = rec_bytes[47:32];
                                w.voltage     = rec_bytes[55:48];
                                w.temperature = rec_bytes[63:56];
                                w.last_record = (records_left == 8'd1);
                                rec_bytes     = 64'd0;
                                records_left  = records_left - 8'd1;
                                if (records_left == 8'd0) begin
                                    state = FRAME_DONE;
                                end
                                queue_word(w);
                                record_words++;
                            end
                        end
                        default: begin
                            busy = 1'b0;
                        end
                    endcase
                end
                srp_pkg::ACT_REG: begin
                    if (lookup(new_id, slot)) begin
                        w.status  = srp_pkg::ST_DUP;
                        w.matched = 1'b1;
                        w.slot    = slot[3:0];
                    end else if (motor_total >= MOTOR_SLOTS) begin
                        w.status = srp_pkg::ST_FULL;
                    end else begin
                        motor_ids[motor_total] = new_id;
                        w.status = srp_pkg::ST_ADDED;
                        w.slot   = motor_total[3:0];
                        motor_total++;
                    end
                    queue_word(w);
                    reg_words++;
                end
                srp_pkg::ACT_NEW: begin
                    state        = WAIT_HDR;
                    byte_idx     = 4'd0;
                    records_left = 8'd0;
                    rec_bytes    = 64'd0;
                    rec_id       = 8'd0;
                end
                default: begin
                    busy = 1'b0;
                end
            endcase
            return busy;
        endfunction

        function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v,
                         act_v);
                errors++;
            end
        endfunction

        function void check_word(srp_pkg::t_rsp got);
            srp_pkg::t_rsp e;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got status %0d", $time,
                         got.status);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            words_checked++;
            check_field("status", e.status, got.status);
            check_field("matched", e.matched, got.matched);
            check_field("slot", e.slot, got.slot);
            check_field("record_id", e.record_id, got.record_id);
            check_field("position", e.position, got.position);
            check_field("speed", e.speed, got.speed);
            check_field("load", e.load, got.load);
            check_field("voltage", e.voltage, got.voltage);
            check_field("temperature", e.temperature, got.temperature);
            check_field("last_record", e.last_record, got.last_record);
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    srp_req_if req_ch ();
    srp_rsp_if rsp_ch ();

    reply_scoreboard sb;
    srp_pkg::t_rsp   rsp_word;
    bit              no_idle;
    int              useful_items;
    int              sent_items;
    int              stall_left;
    int              idle_cycles;

    servo_status_reply_parser_top #(
        .MAX_MOTORS (MOTOR_SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] field_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_id();
        if (sb.motor_total > 0 && $urandom_range(0, 9) < 6) begin
            return sb.motor_ids[$urandom_range(0, sb.motor_total - 1)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // result side: check accepted words, random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_word.status      = rsp_ch.status;
            rsp_word.matched     = rsp_ch.matched;
            rsp_word.slot        = rsp_ch.slot;
            rsp_word.record_id   = rsp_ch.record_id;
            rsp_word.position    = rsp_ch.position;
            rsp_word.speed       = rsp_ch.speed;
            rsp_word.load        = rsp_ch.load;
            rsp_word.voltage     = rsp_ch.voltage;
            rsp_word.temperature = rsp_ch.temperature;
            rsp_word.last_record = rsp_ch.last_record;
            sb.check_word(rsp_word);
        end
        if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL servo_status_reply_parser_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] rx,
                             input logic [7:0] new_id);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.rx_byte      <= rx;
        req_ch.new_motor_id <= new_id;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sent_items++;
        if (sb.note_item(act, rx, new_id)) begin
            useful_items++;
        end
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_item(srp_pkg::ACT_BYTE, rx, 8'($urandom_range(0, 255)));
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_opcode(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_opcode(value);
    endtask

    task automatic send_register();
        int n;
        logic [7:0] id;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if (sb.motor_total > 0 && $urandom_range(0, 3) == 0) begin
                id = sb.motor_ids[$urandom_range(0, sb.motor_total - 1)];
            end else begin
                id = 8'($urandom_range(0, 255));
            end
            send_item(srp_pkg::ACT_REG, 8'($urandom_range(0, 255)), id);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_frame();
        int r;
        int count;
        int n_rec;
        int cut;
        logic [7:0] id;
        if ($urandom_range(0, 9) != 0) begin
            send_item(srp_pkg::ACT_NEW, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        send_byte(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) :
                  srp_pkg::HEADER_BYTE);
        send_byte(($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 255)) : sb.opcode_reg);
        r = $urandom_range(0, 99);
        if (r < 5) begin
            count = 0;
        end else if (r < 80) begin
            count = $urandom_range(1, 3);
        end else if (r < 92) begin
            count = $urandom_range(4, 8);
        end else begin
            count = $urandom_range(0, 255);
        end
        send_byte(count[7:0]);
        // long counts are cut short, the next restart drops the rest
        n_rec = (count > 8) ? $urandom_range(0, 2) : count;
        for (int i = 0; i < n_rec; i++) begin
            id  = pick_id();
            cut = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 8) : 9;
            for (int j = 0; j < cut; j++) begin
                send_byte((j == 0) ? id : field_byte());
            end
            if (cut < 9) begin
                break;
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int r;
        int target;
        logic [7:0] opc;
        sb                  = new();
        no_idle             = 1'b0;
        useful_items        = 0;
        sent_items          = 0;
        stall_left          = 0;
        idle_cycles         = 0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = 8'h00;
        req_ch.valid        = 1'b0;
        req_ch.action       = srp_pkg::ACT_BYTE;
        req_ch.rx_byte      = 8'h00;
        req_ch.new_motor_id = 8'h00;
        rsp_ch.ready        = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_opcode(8'h00);

        // registrations, duplicate, ignored action
        send_item(srp_pkg::ACT_REG, 8'h00, 8'hFF);
        send_item(srp_pkg::ACT_REG, 8'hFF, 8'h00);
        send_item(srp_pkg::ACT_REG, 8'h00, 8'hFF);
        send_item(ACT_IGNORED, 8'hFF, 8'hFF);
        // bad first byte, bad opcode, empty frame
        send_item(srp_pkg::ACT_NEW, 8'h00, 8'h00);
        send_byte(8'h00);
        send_item(srp_pkg::ACT_NEW, 8'h00, 8'h00);
        send_byte(srp_pkg::HEADER_BYTE);
        send_byte(8'h7E);
        send_item(srp_pkg::ACT_NEW, 8'h00, 8'h00);
        send_byte(srp_pkg::HEADER_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
        // one record, all bytes high, matched in slot 0
        send_item(srp_pkg::ACT_NEW, 8'h00, 8'h00);
        send_byte(srp_pkg::HEADER_BYTE);
        send_byte(8'h00);
        send_byte(8'h01);
        for (int j = 0; j < 9; j++) begin
            send_byte(8'hFF);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: opc = 8'hFF;
                2: opc = 8'h00;
                default: opc = 8'($urandom_range(1, 254));
            endcase
            write_opcode(opc);
            no_idle = (ph == 2);
            target  = useful_items + PHASE_ITEMS;
            while (useful_items < target) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    send_register();
                end else if (r < 25) begin
                    send_noise();
                end else begin
                    send_frame();
                end
            end
        end
        settle();

        $display("sent %0d input words (%0d not ignored), checked %0d result words",
                 sent_items, useful_items, sb.words_checked);
        $display("%0d records, %0d header or empty errors, %0d registrations, %0d ids held",
                 sb.record_words, sb.frame_errors, sb.reg_words, sb.motor_total);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("PASS servo_status_reply_parser_top");
        end else begin
            $display("FAIL servo_status_reply_parser_top");
        end
        $finish;
    end

endmodule
